// ===== design/qfd_pkg.sv =====
// package for the quadrature frequency discriminator
// holds beat payload types, the cordic vector type, register indexes and the arctangent table
// no dependencies
`default_nettype none

package qfd_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS = 16;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int SUM_BITS    = PROD_BITS + 1;
    localparam int VEC_BITS    = SUM_BITS + 2;
    localparam int PHASE_BITS  = 16;
    localparam int CFG_BITS    = 16;
    localparam int OUT_BITS    = 20;

    // pre-rotation angles in turns
    localparam logic [PHASE_BITS-1:0] QUARTER_POS = 16'h4000;
    localparam logic [PHASE_BITS-1:0] QUARTER_NEG = 16'hC000;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_OFFSET = 2'd0,
        REG_GAIN   = 2'd1,
        REG_CLAMP  = 2'd2
    } qfd_reg_t;

    // input beat
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_i;
        logic signed [SAMPLE_BITS-1:0] sample_q;
    } qfd_in_t;

    // output beat
    typedef struct packed {
        logic signed [OUT_BITS-1:0] frequency_out;
        logic                       limited;
    } qfd_out_t;

    // vector handed from cell to cell
    typedef struct packed {
        logic                         valid;
        logic                         zero;
        logic signed [VEC_BITS-1:0]   x;
        logic signed [VEC_BITS-1:0]   y;
        logic [PHASE_BITS-1:0]        z;
    } qfd_vec_t;

    // arctangent of 2^-k in turns, Q0.16
    function automatic logic [PHASE_BITS-1:0] atan_turn(input int unsigned k);
        logic [PHASE_BITS-1:0] r;
        case (k)
            0:       r = 16'd8192;
            1:       r = 16'd4836;
            2:       r = 16'd2555;
            3:       r = 16'd1297;
            4:       r = 16'd651;
            5:       r = 16'd326;
            6:       r = 16'd163;
            7:       r = 16'd81;
            8:       r = 16'd41;
            9:       r = 16'd20;
            10:      r = 16'd10;
            11:      r = 16'd5;
            12:      r = 16'd3;
            13:      r = 16'd1;
            14:      r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/quadrature_frequency_discriminator_unit.sv =====
// top level of the quadrature frequency discriminator: config registers and the cell chain
// depends on qfd_pkg, qfd_front, qfd_cell, qfd_back
//
// channel   ports                               direction  payload
// input     s_valid s_ready s_data              in         qfd_in_t  (sample_i, sample_q)
// result    m_valid m_ready m_data              out        qfd_out_t (frequency_out, limited)
// config    cfg_wr_en cfg_index cfg_wr_data     in         offset_turns, gain, clamp_enable
//
// one beat per clock while the output is not stalled; the chain registers are, in order,
// two product stages, pre-rotation, one cordic cell per stage, gain multiply, output register
// reset is synchronous on aresetn low: valid bits and previous sample clear, config registers
// take their reset values (offset 0, gain 1.0, clamp off)
// the whole chain advances together; it holds only while m_valid is high and m_ready is low
`default_nettype none

module quadrature_frequency_discriminator_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire qfd_pkg::qfd_in_t                s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output qfd_pkg::qfd_out_t                    m_data,
    input  wire logic                            cfg_wr_en,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [qfd_pkg::CFG_BITS-1:0]    cfg_wr_data
);

    logic                                 adv;
    logic signed [qfd_pkg::CFG_BITS-1:0]  offset_reg;
    logic signed [qfd_pkg::CFG_BITS-1:0]  gain_reg;
    logic                                 clamp_reg;
    qfd_pkg::qfd_vec_t                    chain [0:CORDIC_STAGES];

    // chain advances unless a finished beat waits
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            gain_reg   <= 16'sd256;
            clamp_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                qfd_pkg::REG_OFFSET: offset_reg <= cfg_wr_data;
                qfd_pkg::REG_GAIN:   gain_reg   <= cfg_wr_data;
                qfd_pkg::REG_CLAMP:  clamp_reg  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    qfd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_valid),
        .in_data  (s_data),
        .vec_out  (chain[0])
    );

    // cordic cells
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        qfd_cell #(
            .SHIFT (g),
            .ATAN  (qfd_pkg::atan_turn(g))
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .vec_in  (chain[g]),
            .vec_out (chain[g+1])
        );
    end

    qfd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .vec_in       (chain[CORDIC_STAGES]),
        .offset_turns (offset_reg),
        .gain         (gain_reg),
        .clamp_enable (clamp_reg),
        .out_valid    (m_valid),
        .out_data     (m_data)
    );

endmodule

`default_nettype wire

// ===== design/qfd_front.sv =====
// front end: conjugate product with the previous sample and half-plane pre-rotation
// depends on qfd_pkg
`default_nettype none

module qfd_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire qfd_pkg::qfd_in_t  in_data,
    output qfd_pkg::qfd_vec_t      vec_out
);

    localparam int SB = qfd_pkg::SAMPLE_BITS;
    localparam int PB = qfd_pkg::PROD_BITS;
    localparam int MB = qfd_pkg::SUM_BITS;
    localparam int VB = qfd_pkg::VEC_BITS;

    logic                 take;
    logic signed [SB-1:0] prev_i_reg;
    logic signed [SB-1:0] prev_q_reg;

    logic                 a_valid_reg;
    logic signed [PB-1:0] p_ii_reg;
    logic signed [PB-1:0] p_qq_reg;
    logic signed [PB-1:0] p_qi_reg;
    logic signed [PB-1:0] p_iq_reg;

    logic                 b_valid_reg;
    logic signed [MB-1:0] re_reg;
    logic signed [MB-1:0] im_reg;

    logic signed [VB-1:0] x0;
    logic signed [VB-1:0] y0;
    qfd_pkg::qfd_vec_t    vec_next;
    qfd_pkg::qfd_vec_t    vec_reg;

    assign take = in_valid & adv;

    // previous sample, updated on every accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_i_reg <= '0;
            prev_q_reg <= '0;
        end else if (take) begin
            prev_i_reg <= in_data.sample_i;
            prev_q_reg <= in_data.sample_q;
        end
    end

    // partial products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            p_ii_reg <= in_data.sample_i * prev_i_reg;
            p_qq_reg <= in_data.sample_q * prev_q_reg;
            p_qi_reg <= in_data.sample_q * prev_i_reg;
            p_iq_reg <= in_data.sample_i * prev_q_reg;
        end
    end

    // real and imaginary parts of current times conjugate of previous
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            re_reg <= MB'(p_ii_reg) + MB'(p_qq_reg);
            im_reg <= MB'(p_qi_reg) - MB'(p_iq_reg);
        end
    end

    // turn the vector into the right half plane
    assign x0 = VB'(re_reg);
    assign y0 = VB'(im_reg);

    always_comb begin
        vec_next.valid = b_valid_reg;
        vec_next.zero  = (re_reg == '0) && (im_reg == '0);
        vec_next.x     = x0;
        vec_next.y     = y0;
        vec_next.z     = '0;
        if (x0[VB-1]) begin
            if (!y0[VB-1]) begin
                vec_next.x = y0;
                vec_next.y = -x0;
                vec_next.z = qfd_pkg::QUARTER_POS;
            end else begin
                vec_next.x = -y0;
                vec_next.y = x0;
                vec_next.z = qfd_pkg::QUARTER_NEG;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_reg.valid <= 1'b0;
        end else if (adv) begin
            vec_reg.valid <= vec_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vec_reg.zero <= vec_next.zero;
            vec_reg.x    <= vec_next.x;
            vec_reg.y    <= vec_next.y;
            vec_reg.z    <= vec_next.z;
        end
    end

    assign vec_out = vec_reg;

endmodule

`default_nettype wire

// ===== design/qfd_cell.sv =====
// one vectoring cordic micro-rotation, registered
// depends on qfd_pkg
`default_nettype none

module qfd_cell #(
    parameter int                                SHIFT = 0,
    parameter logic [qfd_pkg::PHASE_BITS-1:0]    ATAN  = 16'd8192
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire qfd_pkg::qfd_vec_t vec_in,
    output qfd_pkg::qfd_vec_t      vec_out
);

    localparam int VB = qfd_pkg::VEC_BITS;

    logic signed [VB-1:0] xs;
    logic signed [VB-1:0] ys;
    logic                 y_pos;
    qfd_pkg::qfd_vec_t    vec_next;
    qfd_pkg::qfd_vec_t    vec_reg;

    assign xs    = vec_in.x >>> SHIFT;
    assign ys    = vec_in.y >>> SHIFT;
    assign y_pos = !vec_in.y[VB-1] && (vec_in.y != '0);

    // rotate toward the x axis and accumulate the angle
    always_comb begin
        vec_next = vec_in;
        if (y_pos) begin
            vec_next.x = vec_in.x + ys;
            vec_next.y = vec_in.y - xs;
            vec_next.z = vec_in.z + ATAN;
        end else begin
            vec_next.x = vec_in.x - ys;
            vec_next.y = vec_in.y + xs;
            vec_next.z = vec_in.z - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_reg.valid <= 1'b0;
        end else if (adv) begin
            vec_reg.valid <= vec_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vec_reg.zero <= vec_next.zero;
            vec_reg.x    <= vec_next.x;
            vec_reg.y    <= vec_next.y;
            vec_reg.z    <= vec_next.z;
        end
    end

    assign vec_out = vec_reg;

endmodule

`default_nettype wire

// ===== design/qfd_back.sv =====
// back end: offset, gain, rounding to Q7.12, clamp or saturation, output register
// depends on qfd_pkg
`default_nettype none

module qfd_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              adv,
    input  wire qfd_pkg::qfd_vec_t                 vec_in,
    input  wire logic signed [qfd_pkg::CFG_BITS-1:0] offset_turns,
    input  wire logic signed [qfd_pkg::CFG_BITS-1:0] gain,
    input  wire logic                              clamp_enable,
    output logic                                   out_valid,
    output qfd_pkg::qfd_out_t                      out_data
);

    localparam int HB = qfd_pkg::PHASE_BITS;
    localparam int DB = HB + 1;
    localparam int PB = DB + qfd_pkg::CFG_BITS;
    localparam int RB = PB + 1;
    localparam int VB = RB - 12;
    localparam int OB = qfd_pkg::OUT_BITS;

    localparam logic signed [RB-1:0] HALF_LSB  = RB'(2048);
    localparam logic signed [VB-1:0] CLAMP_POS = VB'(4096);
    localparam logic signed [VB-1:0] CLAMP_NEG = -VB'(4096);
    localparam logic signed [VB-1:0] SAT_POS   = VB'((1 << (OB - 1)) - 1);
    localparam logic signed [VB-1:0] SAT_NEG   = -VB'(1 << (OB - 1));

    logic signed [HB-1:0] phase;
    logic signed [DB-1:0] diff;
    logic                 mul_valid_reg;
    logic signed [PB-1:0] prod_reg;
    logic signed [RB-1:0] rounded;
    logic signed [VB-1:0] v;
    qfd_pkg::qfd_out_t    out_next;
    logic                 out_valid_reg;
    qfd_pkg::qfd_out_t    out_reg;

    // phase minus offset, then gain
    assign phase = vec_in.zero ? '0 : $signed(vec_in.z);
    assign diff  = DB'(phase) - DB'(offset_turns);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (adv) begin
            mul_valid_reg <= vec_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= diff * gain;
        end
    end

    // round half up to Q7.12 and limit
    assign rounded = RB'(prod_reg) + HALF_LSB;
    assign v       = rounded[RB-1:12];

    always_comb begin
        out_next.frequency_out = v[OB-1:0];
        out_next.limited       = 1'b0;
        if (clamp_enable) begin
            if (v > CLAMP_POS) begin
                out_next.frequency_out = CLAMP_POS[OB-1:0];
                out_next.limited       = 1'b1;
            end else if (v < CLAMP_NEG) begin
                out_next.frequency_out = CLAMP_NEG[OB-1:0];
                out_next.limited       = 1'b1;
            end
        end else begin
            if (v > SAT_POS) begin
                out_next.frequency_out = SAT_POS[OB-1:0];
                out_next.limited       = 1'b1;
            end else if (v < SAT_NEG) begin
                out_next.frequency_out = SAT_NEG[OB-1:0];
                out_next.limited       = 1'b1;
            end
        end
    end

    // output register, holds while the beat is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
